// File: hw/rtl/qte_pkg.sv
// ---------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and helper functions for the quaternion to
// Euler angle pipeline.
// ---------------------------------------------------------------------------
package qte_pkg;

  // Datapath widths
  localparam int VW      = 34;  // products and vector operands, 2^-30 units
  localparam int AW      = 37;  // CORDIC x/y, room for gain and rotation
  localparam int ZW      = 34;  // angle accumulator, 2^-30 rad
  localparam int SW      = 32;  // arcsine argument, clamped to +-2^30
  localparam int RW      = 61;  // square root radicand and partial root

  localparam int SQRT_STAGES      = 31;
  localparam int CORDIC_ITER_DEF  = 16;
  localparam int PRODUCT_STAGES   = 4;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
  localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [14:0]   YAW_OFFSET_RST = 15'sd5972;

  // Vectors carried alongside the square root
  typedef struct packed {
    logic signed [VW-1:0] roll_y;
    logic signed [VW-1:0] roll_x;
    logic signed [VW-1:0] yaw_y;
    logic signed [VW-1:0] yaw_x;
    logic signed [SW-1:0] s;
  } vec_t;

  // One CORDIC lane
  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 frz;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  // atan(2^-i) in 2^-30 rad
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 34'sd843314857;
      1:       r = 34'sd497837829;
      2:       r = 34'sd263043837;
      3:       r = 34'sd133525159;
      4:       r = 34'sd67021687;
      5:       r = 34'sd33543516;
      6:       r = 34'sd16775851;
      7:       r = 34'sd8388437;
      8:       r = 34'sd4194283;
      9:       r = 34'sd2097149;
      default: r = ZW'(longint'(1) << (30 - i));
    endcase
    return r;
  endfunction

  // Axis cases and left half-plane pre-rotation
  function automatic lane_t lane_init(input logic signed [AW-1:0] y,
                                      input logic signed [AW-1:0] x);
    lane_t l;
    l.x   = x;
    l.y   = y;
    l.z   = '0;
    l.frz = 1'b0;
    if (y == '0) begin
      l.frz = 1'b1;
      l.z   = (x < 0) ? PI_Q30 : '0;
    end else if (x == '0) begin
      l.frz = 1'b1;
      l.z   = (y > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
    end else if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = HALF_PI_Q30;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -HALF_PI_Q30;
      end
    end
    return l;
  endfunction

  // Round half up to Q3.13 and clamp to +-lim
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
                                                input logic signed [15:0] lim);
    logic signed [ZW:0]   t;
    logic signed [ZW-17:0] r;
    logic signed [15:0]   q;
    t = (ZW+1)'(z) + (ZW+1)'(65536);
    r = (ZW-16)'(t >>> 17);
    if (r > (ZW-16)'(lim)) begin
      q = lim;
    end else if (r < -(ZW-16)'(lim)) begin
      q = -lim;
    end else begin
      q = 16'(r);
    end
    return q;
  endfunction

endpackage

// File: hw/rtl/qte_if.sv
// ---------------------------------------------------------------------------
// qte_if
// Valid/ready channels for quaternion words, Euler angle words and the
// heading offset write port.
// ---------------------------------------------------------------------------
interface qte_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface qte_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] yaw_offset;
  modport source (output valid, yaw_offset, input ready);
  modport sink   (input valid, yaw_offset, output ready);
endinterface

// File: hw/rtl/qte_front.sv
// ---------------------------------------------------------------------------
// qte_front
// Product stages: forms the atan2 vectors, the clamped arcsine argument and
// the radicand 1 - s^2 over four registered stages.
// ---------------------------------------------------------------------------
module qte_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [15:0]         quat_w,
  input  logic signed [15:0]         quat_x,
  input  logic signed [15:0]         quat_y,
  input  logic signed [15:0]         quat_z,
  output logic                       out_valid,
  output logic [qte_pkg::RW-1:0]     out_rad,
  output qte_pkg::vec_t              out_vec
);
  import qte_pkg::*;

  logic [PRODUCT_STAGES-1:0] valid_r;

  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, zz_r, wy_r, zx_r, wz_r, xy_r;
  vec_t               vec2_r, vec3_r, vec4_r;
  logic [2*SW-1:0]    sq_r;
  logic [RW-1:0]      rad_r;

  vec_t               vec2_nxt;
  logic signed [VW-1:0] s_full;

  // Combine products into vectors, clamp the arcsine argument
  always_comb begin
    vec2_nxt.roll_y = VW'(2) * (VW'(wx_r) + VW'(yz_r));
    vec2_nxt.roll_x = (VW'(1) <<< 30) - VW'(2) * (VW'(xx_r) + VW'(yy_r));
    vec2_nxt.yaw_y  = VW'(2) * (VW'(wz_r) + VW'(xy_r));
    vec2_nxt.yaw_x  = (VW'(1) <<< 30) - VW'(2) * (VW'(yy_r) + VW'(zz_r));
    s_full          = VW'(2) * (VW'(wy_r) - VW'(zx_r));
    if (s_full > (VW'(1) <<< 30)) begin
      vec2_nxt.s = SW'(1) <<< 30;
    end else if (s_full < -(VW'(1) <<< 30)) begin
      vec2_nxt.s = -(SW'(1) <<< 30);
    end else begin
      vec2_nxt.s = SW'(s_full);
    end
  end

  // Advance the product pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[PRODUCT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r   <= quat_w * quat_x;
      yz_r   <= quat_y * quat_z;
      xx_r   <= quat_x * quat_x;
      yy_r   <= quat_y * quat_y;
      zz_r   <= quat_z * quat_z;
      wy_r   <= quat_w * quat_y;
      zx_r   <= quat_z * quat_x;
      wz_r   <= quat_w * quat_z;
      xy_r   <= quat_x * quat_y;
      vec2_r <= vec2_nxt;
      sq_r   <= unsigned'((2*SW)'(vec2_r.s) * (2*SW)'(vec2_r.s));
      vec3_r <= vec2_r;
      rad_r  <= (RW'(1) << 60) - sq_r[RW-1:0];
      vec4_r <= vec3_r;
    end
  end

  assign out_valid = valid_r[PRODUCT_STAGES-1];
  assign out_rad   = rad_r;
  assign out_vec   = vec4_r;

endmodule

// File: hw/rtl/qte_sqrt_cell.sv
// ---------------------------------------------------------------------------
// qte_sqrt_cell
// One digit of the restoring integer square root; carries the atan2
// vectors alongside.
// ---------------------------------------------------------------------------
module qte_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [qte_pkg::RW-1:0] in_rad,
  input  logic [qte_pkg::RW-1:0] in_res,
  input  qte_pkg::vec_t          in_vec,
  output logic                   out_valid,
  output logic [qte_pkg::RW-1:0] out_rad,
  output logic [qte_pkg::RW-1:0] out_res,
  output qte_pkg::vec_t          out_vec
);
  import qte_pkg::*;

  localparam logic [RW-1:0] BIT_C = RW'(1) << (RW - 1 - 2 * STAGE);

  logic          valid_r;
  logic [RW-1:0] rad_r, res_r, rad_nxt, res_nxt;
  vec_t          vec_r;
  logic [RW:0]   trial;

  // Try the next root bit
  always_comb begin
    trial = {1'b0, in_res} + {1'b0, BIT_C};
    if ({1'b0, in_rad} >= trial) begin
      rad_nxt = in_rad - trial[RW-1:0];
      res_nxt = (in_res >> 1) + BIT_C;
    end else begin
      rad_nxt = in_rad;
      res_nxt = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rad_nxt;
      res_r <= res_nxt;
      vec_r <= in_vec;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_res   = res_r;
  assign out_vec   = vec_r;

endmodule

// File: hw/rtl/qte_cordic_cell.sv
// ---------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation for the roll, pitch and yaw lanes.
// ---------------------------------------------------------------------------
module qte_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  qte_pkg::lanes_t in_lanes,
  output logic            out_valid,
  output qte_pkg::lanes_t out_lanes
);
  import qte_pkg::*;

  localparam logic signed [ZW-1:0] ATAN_C = atan_q30(STAGE);

  logic   valid_r;
  lanes_t lanes_r, lanes_nxt;

  // Rotate each unfrozen lane toward the x axis
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lanes_nxt[l] = in_lanes[l];
      if (!in_lanes[l].frz) begin
        if (in_lanes[l].y > 0) begin
          lanes_nxt[l].x = in_lanes[l].x + (in_lanes[l].y >>> STAGE);
          lanes_nxt[l].y = in_lanes[l].y - (in_lanes[l].x >>> STAGE);
          lanes_nxt[l].z = in_lanes[l].z + ATAN_C;
        end else begin
          lanes_nxt[l].x = in_lanes[l].x - (in_lanes[l].y >>> STAGE);
          lanes_nxt[l].y = in_lanes[l].y + (in_lanes[l].x >>> STAGE);
          lanes_nxt[l].z = in_lanes[l].z - ATAN_C;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_lanes = lanes_r;

endmodule

// File: hw/rtl/quaternion_to_euler_angles_core.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Quaternion (Q1.15) to roll, pitch, yaw (Q3.13) with heading offset.
// ---------------------------------------------------------------------------
// Takes one quaternion word per clock and returns one Euler angle word per
// clock while the output is not stalled. The pipeline is four product stages, a
// 31-cell square root chain for the pitch cosine, one pre-rotation stage,
// one CORDIC cell per iteration shared by the three angles, and the output
// register. Output backpressure stalls the whole chain. Pitch saturates to
// +-pi/2 when 2(wy - zx) leaves [-1, 1]; yaw has yaw_offset subtracted and
// saturates to the 16-bit range. The offset register resets to 5972
// (0.728966 rad) and should be written only while no word is in flight.
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_ITERATIONS = qte_pkg::CORDIC_ITER_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  qte_quat_if.sink     in_ch,
  qte_euler_if.source  out_ch,
  qte_cfg_if.sink      cfg_ch
);
  import qte_pkg::*;

  logic               en;
  logic               out_valid_r;
  logic signed [15:0] roll_r, yaw_r;
  logic signed [14:0] pitch_r;
  logic signed [14:0] yaw_offset_r;

  // Advance everything unless a finished word is held and not accepted
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  // Heading offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_offset_r <= YAW_OFFSET_RST;
    end else if (cfg_ch.valid) begin
      yaw_offset_r <= cfg_ch.yaw_offset;
    end
  end

  // Products and radicand
  logic          fr_valid;
  logic [RW-1:0] fr_rad;
  vec_t          fr_vec;

  qte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .quat_w   (in_ch.quat_w),
    .quat_x   (in_ch.quat_x),
    .quat_y   (in_ch.quat_y),
    .quat_z   (in_ch.quat_z),
    .out_valid(fr_valid),
    .out_rad  (fr_rad),
    .out_vec  (fr_vec)
  );

  // Square root chain
  logic          sq_valid [SQRT_STAGES+1];
  logic [RW-1:0] sq_rad   [SQRT_STAGES+1];
  logic [RW-1:0] sq_res   [SQRT_STAGES+1];
  vec_t          sq_vec   [SQRT_STAGES+1];

  assign sq_valid[0] = fr_valid;
  assign sq_rad[0]   = fr_rad;
  assign sq_res[0]   = '0;
  assign sq_vec[0]   = fr_vec;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    qte_sqrt_cell #(.STAGE(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (sq_valid[k]),
      .in_rad   (sq_rad[k]),
      .in_res   (sq_res[k]),
      .in_vec   (sq_vec[k]),
      .out_valid(sq_valid[k+1]),
      .out_rad  (sq_rad[k+1]),
      .out_res  (sq_res[k+1]),
      .out_vec  (sq_vec[k+1])
    );
  end

  // Pre-rotate and flag axis cases
  logic   pre_valid_r;
  lanes_t pre_lanes_r;
  vec_t   sq_last;
  logic [RW-1:0] root;

  assign sq_last = sq_vec[SQRT_STAGES];
  assign root    = sq_res[SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (en) begin
      pre_valid_r <= sq_valid[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_lanes_r[LANE_ROLL]  <= lane_init(AW'(sq_last.roll_y), AW'(sq_last.roll_x));
      pre_lanes_r[LANE_PITCH] <= lane_init(AW'(sq_last.s),
                                           AW'({1'b0, root[SW-1:0]}));
      pre_lanes_r[LANE_YAW]   <= lane_init(AW'(sq_last.yaw_y), AW'(sq_last.yaw_x));
    end
  end

  // CORDIC chain
  logic   cd_valid [CORDIC_ITERATIONS+1];
  lanes_t cd_lanes [CORDIC_ITERATIONS+1];

  assign cd_valid[0] = pre_valid_r;
  assign cd_lanes[0] = pre_lanes_r;

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
    qte_cordic_cell #(.STAGE(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (cd_valid[i]),
      .in_lanes (cd_lanes[i]),
      .out_valid(cd_valid[i+1]),
      .out_lanes(cd_lanes[i+1])
    );
  end

  // Round, clamp and apply heading offset
  lanes_t             fin;
  logic signed [15:0] roll_nxt, pitch_full, yaw_raw, yaw_nxt;
  logic signed [16:0] yaw_diff;

  assign fin = cd_lanes[CORDIC_ITERATIONS];

  always_comb begin
    roll_nxt   = to_q13(fin[LANE_ROLL].z, PI_Q13);
    pitch_full = to_q13(fin[LANE_PITCH].z, HALF_PI_Q13);
    yaw_raw    = to_q13(fin[LANE_YAW].z, PI_Q13);
    yaw_diff   = 17'(yaw_raw) - 17'(yaw_offset_r);
    if (yaw_diff > 17'sd32767) begin
      yaw_nxt = 16'sh7FFF;
    end else if (yaw_diff < -17'sd32768) begin
      yaw_nxt = 16'sh8000;
    end else begin
      yaw_nxt = yaw_diff[15:0];
    end
  end

  // Output register, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cd_valid[CORDIC_ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_full[14:0];
      yaw_r   <= yaw_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.roll_angle  = roll_r;
  assign out_ch.pitch_angle = pitch_r;
  assign out_ch.yaw_angle   = yaw_r;

endmodule

// File: hw/rtl/qte_checker.sv
// ---------------------------------------------------------------------------
// qte_checker
// Port-level checks for the quaternion to Euler angle core.
// ---------------------------------------------------------------------------
module qte_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] roll_angle,
  input logic signed [14:0] pitch_angle,
  input logic signed [15:0] yaw_angle
);

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(roll_angle) &&
      $stable(pitch_angle) && $stable(yaw_angle))
    else $error("result word changed while stalled");

  // Accept input whenever no result is held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Pitch stays within +-pi/2
  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

  // Roll stays within +-pi
  a_roll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (roll_angle <= 16'sd25736) && (roll_angle >= -16'sd25736))
    else $error("roll out of range");

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .roll_angle (out_ch.roll_angle),
  .pitch_angle(out_ch.pitch_angle),
  .yaw_angle  (out_ch.yaw_angle)
);
